// ===== hdl/pepb_pkg.sv =====
package pepb_pkg;

    localparam int ADDR_FIELD_W = 48;
    localparam int TIME_W       = 32;
    localparam int COUNT_W      = 8;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 1;
    // Slot indexes in the scan record cover the largest table of 64 slots.
    localparam int SLOT_IDX_W   = 6;

    localparam logic [COUNT_W-1:0]    COUNT_MAX      = 8'd255;
    localparam logic [CFG_DATA_W-1:0] BASE_RESET     = 32'd1000;
    localparam logic [CFG_DATA_W-1:0] MAX_RESET      = 32'd30000;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_DELAY = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DELAY  = 1'd1;

    localparam logic [1:0] OP_CHECK   = 2'd0;
    localparam logic [1:0] OP_FAILURE = 2'd1;
    localparam logic [1:0] OP_SUCCESS = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [ADDR_FIELD_W-1:0] peer_address;
        logic [TIME_W-1:0]       now_ms;
    } t_in_beat;

    typedef struct packed {
        logic               blocked;
        logic [TIME_W-1:0]  backoff_ms;
        logic [COUNT_W-1:0] fail_count;
    } t_out_beat;

    // Record handed from cell to cell during a table scan.
    typedef struct packed {
        logic                  found;
        logic [SLOT_IDX_W-1:0] found_idx;
        logic [COUNT_W-1:0]    found_count;
        logic [TIME_W-1:0]     found_last;
        logic                  free_found;
        logic [SLOT_IDX_W-1:0] free_idx;
        logic                  old_valid;
        logic [SLOT_IDX_W-1:0] old_idx;
        logic [TIME_W-1:0]     old_age;
    } t_scan;

    // Slot update broadcast to all cells.
    typedef struct packed {
        logic                  we;
        logic [SLOT_IDX_W-1:0] idx;
        logic [COUNT_W-1:0]    count;
        logic                  load_key;
        logic                  stamp;
    } t_slot_wr;

endpackage

// ===== hdl/pepb_cell.sv =====
module pepb_cell #(
    parameter int KEY_W = 48,
    parameter int IDX   = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [KEY_W-1:0]         i_key,
    input  logic [pepb_pkg::TIME_W-1:0] i_now,
    input  logic                     i_scan_valid,
    input  pepb_pkg::t_scan          i_scan,
    output logic                     o_scan_valid,
    output pepb_pkg::t_scan          o_scan,
    input  pepb_pkg::t_slot_wr       i_wr
);
    import pepb_pkg::*;

    logic [COUNT_W-1:0] r_count;
    logic [KEY_W-1:0]   r_key;
    logic [TIME_W-1:0]  r_last;
    logic               r_scan_valid;
    t_scan              r_scan;
    t_scan              n_scan;

    logic [TIME_W-1:0]  w_age;
    logic               w_occupied;
    logic               w_match;

    localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(IDX);

    assign w_age      = i_now - r_last;
    assign w_occupied = (r_count != '0);
    assign w_match    = w_occupied && (r_key == i_key);

    always_comb begin
        n_scan = i_scan;
        if (w_match && !i_scan.found) begin
            n_scan.found       = 1'b1;
            n_scan.found_idx   = MY_IDX;
            n_scan.found_count = r_count;
            n_scan.found_last  = r_last;
        end
        if (!w_occupied && !i_scan.free_found) begin
            n_scan.free_found = 1'b1;
            n_scan.free_idx   = MY_IDX;
        end
        // strictly older wins, so ties stay with the lower index
        if (!i_scan.old_valid || (w_age > i_scan.old_age)) begin
            n_scan.old_valid = 1'b1;
            n_scan.old_idx   = MY_IDX;
            n_scan.old_age   = w_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_scan_valid <= 1'b0;
        end else begin
            r_scan_valid <= i_scan_valid;
            if (i_wr.we && (i_wr.idx == MY_IDX)) begin
                r_count <= i_wr.count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        if (i_wr.we && (i_wr.idx == MY_IDX)) begin
            if (i_wr.load_key) begin
                r_key <= i_key;
            end
            if (i_wr.stamp) begin
                r_last <= i_now;
            end
        end
    end

    assign o_scan_valid = r_scan_valid;
    assign o_scan       = r_scan;

endmodule

// ===== hdl/pepb_backoff.sv =====
module pepb_backoff (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [pepb_pkg::COUNT_W-1:0]    i_count,
    input  logic [pepb_pkg::TIME_W-1:0]     i_base,
    input  logic [pepb_pkg::TIME_W-1:0]     i_max,
    output logic                            o_done,
    output logic [pepb_pkg::TIME_W-1:0]     o_ms
);
    import pepb_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [TIME_W-1:0]  r_ms;
    logic [COUNT_W-1:0] r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                if (i_count == '0) begin
                    r_ms   <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_ms   <= i_base;
                    r_rem  <= i_count - COUNT_W'(1);
                    r_busy <= 1'b1;
                    r_done <= 1'b0;
                end
            end else if (r_busy) begin
                if (r_rem == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (r_ms >= (i_max >> 1)) begin
                    r_ms   <= i_max;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (r_ms == '0) begin
                    // zero stays zero under doubling
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_ms  <= r_ms << 1;
                    r_rem <= r_rem - COUNT_W'(1);
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_ms   = r_ms;

endmodule

// ===== hdl/per_peer_exponential_backoff_table.sv =====
// Channel   Direction  Handshake                 Beat
// input     in         i_in_valid / o_in_stall   t_in_beat  (opcode, peer_address, now_ms)
// output    out        o_out_valid / i_out_stall t_out_beat (blocked, backoff_ms, fail_count)
// config    in         i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// One beat at a time: the beat is accepted, the scan record walks the row of slot
// cells, the slot is updated and the backoff unit runs its doubling loop (bounded
// by the count and by saturation), then the output register is loaded.
// Reset clears every slot count and restores the delay registers at once.
// A result waiting under i_out_stall holds the next beat in the done state,
// and the input stays stalled until that result moves into the output register.
module per_peer_exponential_backoff_table #(
    parameter int SLOT_COUNT    = 8,
    parameter int ADDRESS_BYTES = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  pepb_pkg::t_in_beat                 i_in_beat,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output pepb_pkg::t_out_beat                o_out_beat,
    input  logic                               i_cfg_we,
    input  logic [pepb_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [pepb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pepb_pkg::*;

    // Only the low address bytes take part, never more than the field holds.
    localparam int KEY_W = (8 * ADDRESS_BYTES < ADDR_FIELD_W) ?
                           8 * ADDRESS_BYTES : ADDR_FIELD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_BACKOFF,
        S_DONE
    } t_state;

    t_state             r_state;
    t_in_beat           r_req;
    logic               r_scan_go;
    logic [CFG_DATA_W-1:0] r_base;
    logic [CFG_DATA_W-1:0] r_max;
    logic [COUNT_W-1:0] r_cnt;
    logic [TIME_W-1:0]  r_last;
    logic [TIME_W-1:0]  r_ms;
    logic               r_out_valid;
    t_out_beat          r_out;

    logic [KEY_W-1:0]   w_key;
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_scan_end;
    t_scan              w_end;
    t_slot_wr           w_wr;
    logic [COUNT_W-1:0] w_cnt;
    logic               w_bo_start;
    logic               w_bo_done;
    logic [TIME_W-1:0]  w_bo_ms;
    logic [TIME_W-1:0]  w_elapsed;

    t_scan              w_chain [SLOT_COUNT+1];
    logic               w_chain_valid [SLOT_COUNT+1];

    assign w_key      = r_req.peer_address[KEY_W-1:0];
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Inject an empty scan record at the head of the row.
    assign w_chain[0]       = '0;
    assign w_chain_valid[0] = r_scan_go;

    genvar g;
    generate
        for (g = 0; g < SLOT_COUNT; g++) begin : g_cell
            pepb_cell #(
                .KEY_W (KEY_W),
                .IDX   (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_key        (w_key),
                .i_now        (r_req.now_ms),
                .i_scan_valid (w_chain_valid[g]),
                .i_scan       (w_chain[g]),
                .o_scan_valid (w_chain_valid[g+1]),
                .o_scan       (w_chain[g+1]),
                .i_wr         (w_wr)
            );
        end
    endgenerate

    assign w_end      = w_chain[SLOT_COUNT];
    assign w_scan_end = (r_state == S_SCAN) && w_chain_valid[SLOT_COUNT];

    // Decide the slot update once the scan record leaves the last cell.
    always_comb begin
        w_wr     = '0;
        w_cnt    = w_end.found ? w_end.found_count : '0;
        case (r_req.opcode)
            OP_FAILURE: begin
                w_wr.we    = w_scan_end;
                w_wr.stamp = 1'b1;
                if (w_end.found) begin
                    w_wr.idx   = w_end.found_idx;
                    w_wr.count = (w_end.found_count == COUNT_MAX) ?
                                 COUNT_MAX : w_end.found_count + COUNT_W'(1);
                end else begin
                    // take the first free slot, else evict the oldest failure
                    w_wr.idx      = w_end.free_found ? w_end.free_idx : w_end.old_idx;
                    w_wr.count    = COUNT_W'(1);
                    w_wr.load_key = 1'b1;
                end
                w_cnt = w_wr.count;
            end
            OP_SUCCESS: begin
                w_wr.we  = w_scan_end && w_end.found;
                w_wr.idx = w_end.found_idx;
                w_cnt    = '0;
            end
            default: begin
            end
        endcase
    end

    assign w_bo_start = w_scan_end;

    pepb_backoff u_backoff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bo_start),
        .i_count (w_cnt),
        .i_base  (r_base),
        .i_max   (r_max),
        .o_done  (w_bo_done),
        .o_ms    (w_bo_ms)
    );

    assign w_elapsed = r_req.now_ms - r_last;

    // Control state, delay registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan_go   <= 1'b0;
            r_out_valid <= 1'b0;
            r_base      <= BASE_RESET;
            r_max       <= MAX_RESET;
        end else begin
            // Launch the scan the cycle after a beat is taken.
            r_scan_go <= w_in_acc;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BASE_DELAY: r_base <= i_cfg_data;
                    REG_MAX_DELAY:  r_max  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // Load a fresh result, else drop the one just taken downstream.
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_scan_end) begin
                        r_state <= S_BACKOFF;
                    end
                end
                S_BACKOFF: begin
                    if (w_bo_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers: request, scan outcome, backoff and the result beat.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req <= i_in_beat;
        end
        if (w_scan_end) begin
            r_cnt  <= w_cnt;
            r_last <= w_end.found_last;
        end
        if ((r_state == S_BACKOFF) && w_bo_done) begin
            r_ms <= w_bo_ms;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out.blocked    <= (r_req.opcode == OP_CHECK) && (w_elapsed < r_ms);
            r_out.backoff_ms <= r_ms;
            r_out.fail_count <= r_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pepb_pkg::*;

    localparam int SLOTS         = 8;
    localparam int ADDR_BYTES    = 6;
    localparam int POOL_MAX      = 16;
    // Give the block time to go quiet after the slowest beat.
    localparam int SETTLE_CYCLES = 48;
    localparam int RUN_LIMIT     = 1_000_000;

    localparam logic [ADDR_FIELD_W-1:0] ADDR_KEEP =
        ADDR_FIELD_W'((65'd1 << (8 * ADDR_BYTES)) - 65'd1);

    // ------------------------------------------------------------------
    // Clock, reset and the ports of the block
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    t_in_beat               in_beat   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_out_beat              out_beat;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    per_peer_exponential_backoff_table #(
        .SLOT_COUNT   (SLOTS),
        .ADDRESS_BYTES(ADDR_BYTES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_beat  (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_beat (out_beat),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow of the backoff table and its delay registers
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]      cnt_tbl   [SLOTS] = '{default: '0};
    logic [ADDR_FIELD_W-1:0] key_tbl   [SLOTS] = '{default: '0};
    logic [TIME_W-1:0]       stamp_tbl [SLOTS] = '{default: '0};
    logic [CFG_DATA_W-1:0]   base_ms = BASE_RESET;
    logic [CFG_DATA_W-1:0]   ceil_ms = MAX_RESET;

    t_in_beat  pending  [$];   // beats waiting for the driver
    t_out_beat expected [$];   // results owed by the block, oldest first
    int        issued_count  = 0;
    int        checked_count = 0;
    int        mismatches    = 0;
    int        cycle_count   = 0;
    bit        calm          = 1'b0;   // no gaps and no stalls while set

    // Random traffic draws most addresses from a small pool of peers, so that
    // hits, refreshes and evictions all happen, and walks a wrapping clock.
    logic [ADDR_FIELD_W-1:0] peer_pool [POOL_MAX];
    int                      pool_n   = 1;
    logic [TIME_W-1:0]       clock_ms = '0;

    // Backoff for a failure count: base, doubled per extra failure, pinned
    // to the ceiling once the value before a doubling reaches half of it.
    function automatic logic [TIME_W-1:0] backoff_of(input logic [COUNT_W-1:0] n);
        logic [TIME_W-1:0] ms;
        int                k;
        if (n == '0)
            return '0;
        ms = base_ms;
        for (k = 1; k < n; k++) begin
            if (ms >= ceil_ms / 2)
                return ceil_ms;
            ms = ms << 1;
        end
        return ms;
    endfunction

    // Apply one beat to the shadow table and return the result it owes.
    function automatic t_out_beat apply_beat(input t_in_beat b);
        t_out_beat               r;
        logic [ADDR_FIELD_W-1:0] key;
        logic [TIME_W-1:0]       age_k;
        logic [TIME_W-1:0]       age_old;
        logic [COUNT_W-1:0]      n;
        int                      hit;
        int                      k;
        r   = '0;
        n   = '0;
        hit = -1;
        key = b.peer_address & ADDR_KEEP;
        // Empty slots never match, whatever address they still hold.
        for (k = 0; k < SLOTS; k++)
            if (hit < 0 && cnt_tbl[k] != '0 && key_tbl[k] == key)
                hit = k;
        case (b.opcode)
            OP_CHECK: begin
                if (hit >= 0) begin
                    n       = cnt_tbl[hit];
                    age_k   = b.now_ms - stamp_tbl[hit];
                    r.blocked = (age_k < backoff_of(n));
                end
            end
            OP_FAILURE: begin
                // New peer: take the first empty slot ...
                for (k = 0; k < SLOTS; k++)
                    if (hit < 0 && cnt_tbl[k] == '0)
                        hit = k;
                // ... else evict the stalest failure, ties to the lowest index.
                if (hit < 0) begin
                    hit = 0;
                    for (k = 1; k < SLOTS; k++) begin
                        age_k   = b.now_ms - stamp_tbl[k];
                        age_old = b.now_ms - stamp_tbl[hit];
                        if (age_k > age_old)
                            hit = k;
                    end
                    cnt_tbl[hit] = '0;
                end
                if (cnt_tbl[hit] == '0) begin
                    key_tbl[hit] = key;
                    cnt_tbl[hit] = COUNT_W'(1);
                end else if (cnt_tbl[hit] != COUNT_MAX) begin
                    cnt_tbl[hit] = cnt_tbl[hit] + 1'b1;
                end
                stamp_tbl[hit] = b.now_ms;
                n = cnt_tbl[hit];
            end
            OP_SUCCESS: begin
                if (hit >= 0)
                    cnt_tbl[hit] = '0;
            end
            default: begin
                if (hit >= 0)
                    n = cnt_tbl[hit];
            end
        endcase
        r.backoff_ms = backoff_of(n);
        r.fail_count = n;
        return r;
    endfunction

    // Gap or stall length: mostly none, often short, now and then long.
    function automatic int pause_len();
        int pick;
        if (calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report(input string msg);
        mismatches++;
        $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Driver: present beats from the pending queue, hold them while stalled
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            // Accepted beat: predict its result right away, in accept order.
            if (in_valid && !in_stall)
                expected.push_back(apply_beat(in_beat));
            // Load the next beat only once the current one is gone.
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending.size() != 0) begin
                    in_beat  <= pending.pop_front();
                    in_valid <= 1'b1;
                    gap_left = pause_len();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result beat with the oldest expectation
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge i_clk) begin : result_monitor
        t_out_beat want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected.size() == 0) begin
                    report($sformatf("result beat with nothing outstanding: %p", out_beat));
                end else begin
                    want = expected.pop_front();
                    if (out_beat.blocked !== want.blocked)
                        report($sformatf("result %0d blocked: got %0b want %0b",
                                         checked_count, out_beat.blocked, want.blocked));
                    if (out_beat.backoff_ms !== want.backoff_ms)
                        report($sformatf("result %0d backoff_ms: got %0d want %0d",
                                         checked_count, out_beat.backoff_ms,
                                         want.backoff_ms));
                    if (out_beat.fail_count !== want.fail_count)
                        report($sformatf("result %0d fail_count: got %0d want %0d",
                                         checked_count, out_beat.fail_count,
                                         want.fail_count));
                    checked_count++;
                end
            end
            // Stall at random, independent of whether a result is showing.
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                stall_left = pause_len();
                out_stall <= (stall_left > 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic put(input logic [1:0] op, input logic [ADDR_FIELD_W-1:0] addr,
                       input logic [TIME_W-1:0] now);
        t_in_beat b;
        b.opcode       = op;
        b.peer_address = addr;
        b.now_ms       = now;
        pending.push_back(b);
        issued_count++;
    endtask

    // Wait until every issued beat has its result back, then let the block settle.
    task automatic drain();
        while (checked_count != issued_count)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both delay registers; only call with the block idle.
    task automatic program_delays(input logic [CFG_DATA_W-1:0] base,
                                  input logic [CFG_DATA_W-1:0] ceil);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BASE_DELAY;
        cfg_data  <= base;
        base_ms   = base;
        @(posedge i_clk);
        cfg_index <= REG_MAX_DELAY;
        cfg_data  <= ceil;
        ceil_ms   = ceil;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // One random beat. In hammer mode, pound the first pool peer with
    // failures so its count climbs through every doubling into saturation.
    function automatic t_in_beat random_beat(input bit hammer);
        t_in_beat          b;
        int                pick;
        logic [TIME_W-1:0] span;
        pick = $urandom_range(0, 99);
        if (hammer)
            b.opcode = (pick < 85) ? OP_FAILURE : (pick < 93) ? OP_QUERY : OP_CHECK;
        else if (pick < 35)
            b.opcode = OP_FAILURE;
        else if (pick < 65)
            b.opcode = OP_CHECK;
        else if (pick < 80)
            b.opcode = OP_SUCCESS;
        else
            b.opcode = OP_QUERY;

        if (hammer)
            b.peer_address = peer_pool[0];
        else if ($urandom_range(0, 99) < 88)
            b.peer_address = peer_pool[$urandom_range(0, pool_n - 1)];
        else
            b.peer_address = ADDR_FIELD_W'({$urandom, $urandom});

        // Step the clock on the scale of the base delay so that checks land
        // on both sides of the backoff; hold it still at times for age ties.
        span = (base_ms > 32'd100000) ? 32'd100000 : base_ms;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            b.now_ms = $urandom;
        end else begin
            if (pick < 25)
                clock_ms = clock_ms;
            else if (pick < 75)
                clock_ms = clock_ms + $urandom_range(0, span);
            else if (pick < 97)
                clock_ms = clock_ms + $urandom_range(0, 60000);
            else
                clock_ms = clock_ms + $urandom;
            b.now_ms = clock_ms;
        end
        return b;
    endfunction

    task automatic run_random(input int n, input bit hammer);
        t_in_beat b;
        int       k;
        @(negedge i_clk);
        calm   = ($urandom_range(0, 3) == 0);
        pool_n = $urandom_range(4, POOL_MAX);
        for (k = 0; k < POOL_MAX; k++)
            peer_pool[k] = ADDR_FIELD_W'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0:       peer_pool[0] = '0;
            1:       peer_pool[0] = '1;
            default: ;
        endcase
        clock_ms = $urandom;
        repeat (n) begin
            b = random_beat(hammer);
            put(b.opcode, b.peer_address, b.now_ms);
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int k;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats under the reset delays (1000 / 30000 ms).
        @(negedge i_clk);
        // Unknown peer on an empty table: all zeros for every operation.
        put(OP_QUERY,   '0, '0);
        put(OP_CHECK,   '1, '1);
        put(OP_SUCCESS, 48'h0000_0000_0123, 32'd77);
        // First failure just before the clock wraps, checks just after it.
        put(OP_FAILURE, '1, 32'hFFFF_FF00);
        put(OP_CHECK,   '1, 32'h0000_0100);   // 512 ms elapsed, still blocked
        put(OP_CHECK,   '1, 32'h0000_02E8);   // exactly the backoff, released
        put(OP_FAILURE, '1, 32'h0000_0300);   // known peer, count rises to two, backoff doubles
        put(OP_QUERY,   '1, 32'h0000_0400);
        put(OP_SUCCESS, '1, 32'h0000_0500);   // frees the slot
        put(OP_QUERY,   '1, 32'h0000_0600);
        // Fill the table: four peers stamped at 5000, four at 4000.
        for (k = 0; k < SLOTS; k++)
            put(OP_FAILURE, {8'(k), 32'h0, 8'(k)}, (k < 4) ? 32'd5000 : 32'd4000);
        // Full table: evict among tied oldest entries, then again later.
        put(OP_FAILURE, 48'h0A0A_0A0A_0A0A, 32'd5000);
        put(OP_FAILURE, 48'h5555_5555_5555, 32'd9000);
        put(OP_QUERY,   {8'd4, 32'h0, 8'd4}, 32'd9001);
        put(OP_CHECK,   {8'd7, 32'h0, 8'd7}, 32'd4999);
        put(OP_FAILURE, {8'd7, 32'h0, 8'd7}, 32'd5000);
        put(OP_SUCCESS, {8'd3, 32'h0, 8'd3}, 32'd5100);
        put(OP_FAILURE, 48'h8000_0000_0001, 32'd0);   // takes the freed slot
        drain();

        run_random(110, 1'b0);

        // Widest range: count climbs all the way to 255 before saturating.
        program_delays(32'd1, 32'hFFFF_FFFF);
        run_random(320, 1'b1);

        // Base above the ceiling: count one reports base, the rest the ceiling.
        program_delays(32'hFFFF_FFFF, 32'd1);
        run_random(140, 1'b0);

        program_delays(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(100, 1'b0);

        program_delays($urandom_range(1, 5000), $urandom_range(1, 200000));
        run_random(140, 1'b0);

        program_delays($urandom | 32'd1, $urandom | 32'd1);
        run_random(100, 1'b0);

        program_delays(32'd1, 32'd1);
        run_random(60, 1'b0);

        program_delays(32'd7, 32'd5000);
        run_random(100, 1'b1);
        run_random(60, 1'b0);

        if (expected.size() != 0)
            report($sformatf("%0d results never arrived", expected.size()));
        if (mismatches == 0) begin
            $display("per_peer_exponential_backoff_table test passed");
        end else begin
            $display("per_peer_exponential_backoff_table test failed");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin : watchdog
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("per_peer_exponential_backoff_table test failed");
        $finish;
    end

endmodule
